>>> rtl/kfpi_pkg.sv
package kfpi_pkg;

    // Item modes.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_SEEK    = 2'd2;
    localparam logic [1:0] MODE_REWIND  = 2'd3;

    // Fraction of one in Q1.16.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_ARD  = 12'b000000000010,
        ST_ACHK = 12'b000000000100,
        ST_SRD  = 12'b000000001000,
        ST_SCHK = 12'b000000010000,
        ST_PRD  = 12'b000000100000,
        ST_PGET = 12'b000001000000,
        ST_W0   = 12'b000010000000,
        ST_SET  = 12'b000100000000,
        ST_DIV  = 12'b001000000000,
        ST_MUL  = 12'b010000000000,
        ST_ACC  = 12'b100000000000
    } state_t;

endpackage

>>> rtl/kfpi_div.sv
module kfpi_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quo
);
    import kfpi_pkg::*;

    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [32:0] shifted;

    // One quotient bit per cycle, restoring form; num is below den.
    always_comb
    begin
        shifted  = {rem_reg[31:0], 1'b0};
        rem_next = shifted;
        quo_next = {quo_reg[14:0], 1'b0};
        if (shifted >= {1'b0, den_reg})
        begin
            rem_next = shifted - {1'b0, den_reg};
            quo_next = {quo_reg[14:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    // A result only follows a running division.
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg)) else $error("divider done without run");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !start) else $error("divider restarted while running");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg) else $error("divider still running at done");

endmodule

>>> rtl/keyframe_path_interpolator_unit.sv
// Channel  | Signals                                          | Beat taken when
// ---------+--------------------------------------------------+-------------------
// command  | start, mode, time_value, restart_table, coord_*  | start & !busy
// result   | done, pos_x/y/z, active, wrapped, segment,       | done (one cycle)
//          | table_full                                       |
// config   | cfg_valid, cfg_ready, cfg_data (loop_enable)      | cfg_valid & cfg_ready
//
// A load needs no search; a rewind reads at most the first waypoint. An advance
// reads and checks table entries one at a time (one memory read each), then runs
// the shared divider unless the fraction saturates at one, and the three
// interpolations; a seek adds the read of the earlier waypoint. Reset clears all
// control state; the waypoint memories are not cleared. The receiver cannot stall
// the result.
module keyframe_path_interpolator_unit
#(
    parameter int MAX_WAYPOINTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] time_value,
    input  logic        restart_table,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic        done,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic        active,
    output logic        wrapped,
    output logic [7:0]  segment,
    output logic        table_full,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import kfpi_pkg::*;

    localparam int IW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_WAYPOINTS);

    // Waypoint memories: times and packed x/y/z.
    logic [31:0] time_mem [MAX_WAYPOINTS];
    logic [95:0] coord_mem [MAX_WAYPOINTS];
    logic [31:0] time_q;
    logic [95:0] coord_q;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0] wr_time;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] ptime_reg, ptime_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic        run_reg, run_next;
    logic        loop_reg;
    logic        done_reg, done_next;
    logic        wrap_reg, wrap_next;
    logic        full_reg, full_next;
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] tv_reg, tv_next;
    logic [31:0] pos_reg [3];
    logic [31:0] pos_next [3];
    logic [31:0] ca_reg [3];
    logic [31:0] ca_next [3];
    logic [31:0] cb_reg [3];
    logic [31:0] cb_next [3];
    logic [31:0] tb_reg, tb_next;
    logic [16:0] r_reg, r_next;
    logic [1:0]  axis_reg, axis_next;
    logic signed [50:0] prod_reg, prod_next;

    logic        div_start;
    logic [31:0] div_num, div_den;
    logic        div_done;
    logic [15:0] div_quo;

    logic        accept;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] nidx;
    logic [31:0] den_w, num_w;
    logic [32:0] sum_w;
    logic signed [32:0] diff_w;
    logic signed [50:0] rnd_w;
    logic signed [32:0] step_w;
    logic [IW+7:0] seg_w;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Memory write and registered read at the current index.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr]  <= wr_time;
            coord_mem[wr_addr] <= {coord_z, coord_y, coord_x};
        end
        time_q  <= time_mem[idx_reg];
        coord_q <= coord_mem[idx_reg];
    end

    kfpi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Interpolation arithmetic for the current axis.
    always_comb
    begin
        diff_w = $signed({cb_reg[axis_reg][31], cb_reg[axis_reg]})
               - $signed({ca_reg[axis_reg][31], ca_reg[axis_reg]});
        rnd_w  = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd0);
        step_w = rnd_w[48:16];
        sum_w  = {1'b0, ptime_reg} + {1'b0, tv_reg};
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        base_next  = base_reg;
        ptime_next = ptime_reg;
        idx_next   = idx_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        wrap_next  = wrap_reg;
        full_next  = full_reg;
        mode_next  = mode_reg;
        tv_next    = tv_reg;
        pos_next   = pos_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        tb_next    = tb_reg;
        r_next     = r_reg;
        axis_next  = axis_reg;
        prod_next  = prod_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IW-1:0];
        wr_time    = '0;
        eff_count  = restart_table ? '0 : count_reg;
        nidx       = CW'(idx_reg) + CW'(1);
        div_start  = 1'b0;
        den_w      = '0;
        num_w      = '0;
        div_num    = num_w;
        div_den    = den_w;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wrap_next = 1'b0;
                    full_next = 1'b0;
                    mode_next = mode;
                    tv_next   = time_value;
                    case (mode)
                        MODE_LOAD:
                        begin
                            count_next = eff_count;
                            if (eff_count >= MAX_C)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = eff_count[IW-1:0];
                                if (eff_count == '0)
                                begin
                                    base_next  = time_value;
                                    ptime_next = '0;
                                    idx_next   = '0;
                                    wr_time    = '0;
                                end
                                else
                                begin
                                    wr_time = time_value - base_reg;
                                end
                                count_next = eff_count + CW'(1);
                                run_next   = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        MODE_ADVANCE:
                        begin
                            if (run_reg && (count_reg != '0) && (CW'(idx_reg) < count_reg))
                                state_next = ST_ARD;
                            else
                                done_next = 1'b1;
                        end
                        MODE_SEEK:
                        begin
                            if (run_reg && (count_reg != '0))
                            begin
                                ptime_next = (time_value >= base_reg) ?
                                             time_value - base_reg : '0;
                                if (count_reg < CW'(2))
                                begin
                                    idx_next   = '0;
                                    state_next = ST_W0;
                                end
                                else
                                begin
                                    idx_next   = IW'(1);
                                    state_next = ST_SRD;
                                end
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        MODE_REWIND:
                        begin
                            ptime_next = '0;
                            idx_next   = '0;
                            if (!loop_reg)
                            begin
                                run_next  = 1'b0;
                                done_next = 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                state_next = ST_W0;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ARD:
            begin
                state_next = ST_ACHK;
            end
            ST_ACHK:
            begin
                if (ptime_reg >= time_q)
                begin
                    if (nidx >= count_reg)
                    begin
                        wrap_next  = 1'b1;
                        ptime_next = '0;
                        idx_next   = '0;
                        if (loop_reg)
                        begin
                            state_next = ST_W0;
                        end
                        else
                        begin
                            run_next   = 1'b0;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = nidx[IW-1:0];
                        state_next = ST_ARD;
                    end
                end
                else
                begin
                    den_w   = time_q - ptime_reg;
                    num_w   = tv_reg;
                    div_num = num_w;
                    div_den = den_w;
                    ca_next = pos_reg;
                    cb_next[0] = coord_q[31:0];
                    cb_next[1] = coord_q[63:32];
                    cb_next[2] = coord_q[95:64];
                    axis_next = '0;
                    if (num_w >= den_w)
                    begin
                        r_next     = ONE_Q16;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (ptime_reg > time_q)
                begin
                    if (nidx >= count_reg)
                    begin
                        wrap_next  = 1'b1;
                        ptime_next = '0;
                        idx_next   = '0;
                        if (loop_reg)
                        begin
                            state_next = ST_W0;
                        end
                        else
                        begin
                            run_next   = 1'b0;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next   = nidx[IW-1:0];
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    tb_next    = time_q;
                    cb_next[0] = coord_q[31:0];
                    cb_next[1] = coord_q[63:32];
                    cb_next[2] = coord_q[95:64];
                    idx_next   = idx_reg - IW'(1);
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
            begin
                state_next = ST_PGET;
            end
            ST_PGET:
            begin
                // Earlier waypoint is on the read port; restore the target index.
                idx_next   = idx_reg + IW'(1);
                ca_next[0] = coord_q[31:0];
                ca_next[1] = coord_q[63:32];
                ca_next[2] = coord_q[95:64];
                axis_next  = '0;
                num_w      = (ptime_reg > time_q) ? ptime_reg - time_q : '0;
                den_w      = tb_reg - time_q;
                div_num    = num_w;
                div_den    = den_w;
                if ((tb_reg <= time_q) || (num_w >= den_w))
                begin
                    r_next     = ONE_Q16;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_W0:
            begin
                state_next = ST_SET;
            end
            ST_SET:
            begin
                pos_next[0] = coord_q[31:0];
                pos_next[1] = coord_q[63:32];
                pos_next[2] = coord_q[95:64];
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    r_next     = {1'b0, div_quo};
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = 51'(diff_w * $signed({1'b0, r_reg}));
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                pos_next[axis_reg] = ca_reg[axis_reg] + step_w[31:0];
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    if (mode_reg == MODE_ADVANCE)
                        ptime_next = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            base_reg  <= '0;
            ptime_reg <= '0;
            idx_reg   <= '0;
            run_reg   <= 1'b0;
            loop_reg  <= 1'b1;
            done_reg  <= 1'b0;
            wrap_reg  <= 1'b0;
            full_reg  <= 1'b0;
            pos_reg   <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            base_reg  <= base_next;
            ptime_reg <= ptime_next;
            idx_reg   <= idx_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            wrap_reg  <= wrap_next;
            full_reg  <= full_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready)
                loop_reg <= cfg_data;
        end
    end

    // Working payload.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        tv_reg   <= tv_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        tb_reg   <= tb_next;
        r_reg    <= r_next;
        axis_reg <= axis_next;
        prod_reg <= prod_next;
    end

    // Result ports.
    assign seg_w      = {8'd0, idx_reg};
    assign done       = done_reg;
    assign pos_x      = pos_reg[0];
    assign pos_y      = pos_reg[1];
    assign pos_z      = pos_reg[2];
    assign active     = run_reg;
    assign wrapped    = wrap_reg;
    assign segment    = seg_w[7:0];
    assign table_full = full_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE)) else $error("result while busy");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((idx_reg == '0) || (CW'(idx_reg) < count_reg)))
        else $error("index beyond table");
    a_full_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && full_reg) |-> (count_reg == MAX_C)) else $error("bad full flag");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C) else $error("count beyond table");

endmodule

>>> bench/tb_keyframe_path_interpolator_unit.sv
module tb_keyframe_path_interpolator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import kfpi_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int RANDOM_ITEMS = 620;
    localparam longint CYCLE_LIMIT = 2000000;

    // One command beat and one position report.
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] tval;
        logic        restart;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
    } command_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        act;
        logic        wrap;
        logic [7:0]  seg;
        logic        full;
    } report_t;

    typedef struct {
        command_t cmd;
        logic     typed;
        report_t  rep;
    } vector_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_LOAD;
    logic [31:0] time_value = '0;
    logic        restart_table = 1'b0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic        done;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        active;
    logic        wrapped;
    logic [7:0]  segment;
    logic        table_full;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // Shadow copy of the path state.
    logic [31:0] pt_time [TABLE_DEPTH];
    logic [31:0] pt_x [TABLE_DEPTH];
    logic [31:0] pt_y [TABLE_DEPTH];
    logic [31:0] pt_z [TABLE_DEPTH];
    int unsigned pt_count;
    logic [31:0] t_base;
    logic [31:0] t_path;
    int unsigned idx;
    logic [31:0] here [3];
    logic        moving;
    logic        wrap_on;

    report_t     pending_positions [$];
    int unsigned error_count = 0;
    int unsigned report_count = 0;
    int unsigned wrap_count = 0;
    int unsigned full_count = 0;
    longint      cycle_count = 0;

    keyframe_path_interpolator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .time_value    (time_value),
        .restart_table (restart_table),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .done          (done),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .active        (active),
        .wrapped       (wrapped),
        .segment       (segment),
        .table_full    (table_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Cycle limit guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    // Q1.16 fraction num/den, saturated at one.
    function automatic logic [31:0] ratio_q16(input logic [31:0] num,
                                              input logic [31:0] den);
        if (den == 0 || num >= den)
            return 32'h10000;
        return 32'(({32'd0, num} << 16) / {32'd0, den});
    endfunction

    // Step from a toward b by fraction r, truncating toward zero.
    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] r);
        longint d;
        longint s;
        d = longint'(signed'(b)) - longint'(signed'(a));
        s = (d * longint'(r)) / 65536;
        return 32'(longint'(signed'(a)) + s);
    endfunction

    function automatic void jump_to(input int unsigned i);
        here[0] = pt_x[i];
        here[1] = pt_y[i];
        here[2] = pt_z[i];
    endfunction

    function automatic void reach_end();
        t_path = 0;
        idx = 0;
        if (wrap_on)
            jump_to(0);
        else
            moving = 1'b0;
    endfunction

    function automatic void clear_path_state();
        pt_count = 0;
        t_base = 0;
        t_path = 0;
        idx = 0;
        here[0] = 0;
        here[1] = 0;
        here[2] = 0;
        moving = 1'b0;
        wrap_on = 1'b1;
    endfunction

    // Expected position report for one command.
    function automatic report_t next_position(input command_t c);
        report_t     r;
        logic        hit_end;
        logic        full;
        logic [31:0] f;
        logic [31:0] num;
        int unsigned p;
        hit_end = 1'b0;
        full = 1'b0;
        case (c.mode)
            MODE_LOAD:
            begin
                if (c.restart)
                    pt_count = 0;
                if (pt_count >= TABLE_DEPTH)
                    full = 1'b1;
                else
                begin
                    if (pt_count == 0)
                    begin
                        t_base = c.tval;
                        t_path = 0;
                        idx = 0;
                    end
                    pt_time[pt_count] = c.tval - t_base;
                    pt_x[pt_count] = c.cx;
                    pt_y[pt_count] = c.cy;
                    pt_z[pt_count] = c.cz;
                    pt_count++;
                    moving = 1'b1;
                end
            end
            MODE_ADVANCE:
            begin
                if (moving && pt_count > 0 && idx < pt_count)
                begin
                    while (t_path >= pt_time[idx])
                    begin
                        idx++;
                        if (idx >= pt_count)
                        begin
                            hit_end = 1'b1;
                            reach_end();
                            break;
                        end
                    end
                    if (!hit_end)
                    begin
                        f = ratio_q16(c.tval, pt_time[idx] - t_path);
                        here[0] = blend(here[0], pt_x[idx], f);
                        here[1] = blend(here[1], pt_y[idx], f);
                        here[2] = blend(here[2], pt_z[idx], f);
                        t_path = (t_path > 32'hFFFF_FFFF - c.tval) ? 32'hFFFF_FFFF
                                                                     : t_path + c.tval;
                    end
                end
            end
            MODE_SEEK:
            begin
                if (moving && pt_count > 0)
                begin
                    t_path = (c.tval >= t_base) ? c.tval - t_base : 32'd0;
                    if (pt_count < 2)
                    begin
                        idx = 0;
                        jump_to(0);
                    end
                    else
                    begin
                        idx = 1;
                        while (t_path > pt_time[idx])
                        begin
                            idx++;
                            if (idx >= pt_count)
                            begin
                                hit_end = 1'b1;
                                reach_end();
                                break;
                            end
                        end
                        if (!hit_end)
                        begin
                            p = idx - 1;
                            num = (t_path > pt_time[p]) ? t_path - pt_time[p] : 32'd0;
                            f = (pt_time[idx] > pt_time[p])
                                ? ratio_q16(num, pt_time[idx] - pt_time[p]) : 32'h10000;
                            here[0] = blend(pt_x[p], pt_x[idx], f);
                            here[1] = blend(pt_y[p], pt_y[idx], f);
                            here[2] = blend(pt_z[p], pt_z[idx], f);
                        end
                    end
                end
            end
            default:
            begin
                t_path = 0;
                idx = 0;
                if (!wrap_on)
                    moving = 1'b0;
                else if (pt_count > 0)
                    jump_to(0);
            end
        endcase
        r.px = here[0];
        r.py = here[1];
        r.pz = here[2];
        r.act = moving;
        r.wrap = hit_end;
        r.seg = 8'(idx);
        r.full = full;
        return r;
    endfunction

    // Compare each strobed report against the oldest expectation.
    always @(posedge clk)
    begin
        report_t w;
        if (rst_n && done)
        begin
            if (pending_positions.size() == 0)
            begin
                $display("Unexpected report at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                w = pending_positions.pop_front();
                report_count++;
                if (w.wrap)
                    wrap_count++;
                if (w.full)
                    full_count++;
                if (pos_x !== w.px) report_mismatch("pos_x", pos_x, w.px);
                if (pos_y !== w.py) report_mismatch("pos_y", pos_y, w.py);
                if (pos_z !== w.pz) report_mismatch("pos_z", pos_z, w.pz);
                if (active !== w.act) report_mismatch("active", active, w.act);
                if (wrapped !== w.wrap) report_mismatch("wrapped", wrapped, w.wrap);
                if (segment !== w.seg) report_mismatch("segment", segment, w.seg);
                if (table_full !== w.full)
                    report_mismatch("table_full", table_full, w.full);
            end
        end
    end

    // Sender gaps: bursts of back-to-back beats, then a random pause.
    int burst_left = 0;

    task automatic issue(input command_t c, input logic typed, input report_t want);
        report_t p;
        int      gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        mode <= c.mode;
        time_value <= c.tval;
        restart_table <= c.restart;
        coord_x <= c.cx;
        coord_y <= c.cy;
        coord_z <= c.cz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = next_position(c);
        if (typed && p !== want)
        begin
            $display("Predictor disagrees with typed row at cycle %0d", cycle_count);
            error_count++;
        end
        pending_positions = {pending_positions, p};
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // Register write only while nothing is in flight.
    task automatic set_wrap(input logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        wrap_on = v;
        @(posedge clk);
    endtask

    function automatic command_t make_cmd(input logic [1:0] m, input logic [31:0] t,
                                          input logic rs, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
        command_t c;
        c.mode = m;
        c.tval = t;
        c.restart = rs;
        c.cx = x;
        c.cy = y;
        c.cz = z;
        return c;
    endfunction

    function automatic report_t make_rep(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input logic a,
                                         input logic w, input logic [7:0] s,
                                         input logic f);
        report_t r;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.act = a;
        r.wrap = w;
        r.seg = s;
        r.full = f;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
            default: return $urandom;
        endcase
    endfunction

    vector_t directed [$];
    report_t none;

    function automatic void add_row(input vector_t v);
        directed = {directed, v};
    endfunction

    initial
    begin
        command_t c;
        int unsigned k;
        int unsigned n;
        int unsigned t;
        clear_path_state();
        none = make_rep(0, 0, 0, 0, 0, 0, 0);

        // Directed rows: idle behavior, extremes and path corner cases.
        add_row('{make_cmd(MODE_ADVANCE, 10, 0, 0, 0, 0), 1, none});
        add_row('{make_cmd(MODE_SEEK, 5, 0, 0, 0, 0), 1, none});
        add_row('{make_cmd(MODE_REWIND, 0, 0, 0, 0, 0), 1, none});
        add_row('{make_cmd(MODE_LOAD, 32'hFFFF_FFF0, 1, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h0001_0000), 1,
                  make_rep(0, 0, 0, 1, 0, 0, 0)});
        add_row('{make_cmd(MODE_SEEK, 0, 0, 0, 0, 0), 1,
                  make_rep(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                           1, 0, 0, 0)});
        add_row('{make_cmd(MODE_LOAD, 32'h0000_0010, 0, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'hFFFF_0000), 0, none});
        add_row('{make_cmd(MODE_LOAD, 32'h0000_0010, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_LOAD, 32'h0000_0008, 0, 32'h0003_0000,
                           1, 32'hFFFF_FFFF), 0, none});
        add_row('{make_cmd(MODE_ADVANCE, 7, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_ADVANCE, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_ADVANCE, 0, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_ADVANCE, 3, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_ADVANCE, 1, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_SEEK, 32'h0000_0005, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_SEEK, 32'h0000_0004, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_SEEK, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_SEEK, 32'h8000_0000, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_REWIND, 0, 0, 0, 0, 0), 0, none});
        add_row('{make_cmd(MODE_LOAD, 32'h0000_0000, 1, 32'h0000_4000,
                           32'hFFFF_C000, 0), 0, none});
        add_row('{make_cmd(MODE_SEEK, 32'h0000_0100, 0, 0, 0, 0), 0, none});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[j])
            issue(directed[j].cmd, directed[j].typed, directed[j].rep);

        // Stopping mode: path end and rewind clear the running flag.
        set_wrap(1'b0);
        c = make_cmd(MODE_LOAD, 100, 1, 32'h0001_0000, 0, 0);
        issue(c, 0, none);
        c = make_cmd(MODE_LOAD, 200, 0, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        issue(c, 0, none);
        issue(make_cmd(MODE_ADVANCE, 50, 0, 0, 0, 0), 0, none);
        issue(make_cmd(MODE_SEEK, 1000, 0, 0, 0, 0), 0, none);
        issue(make_cmd(MODE_ADVANCE, 5, 0, 0, 0, 0), 0, none);
        issue(make_cmd(MODE_REWIND, 0, 0, 0, 0, 0), 0, none);
        set_wrap(1'b1);

        // Fill the table past its depth to hit the full flag.
        for (k = 0; k < TABLE_DEPTH + 3; k++)
        begin
            c = make_cmd(MODE_LOAD, k * 16, k == 0, rand_coord(), rand_coord(),
                         rand_coord());
            issue(c, 0, none);
        end
        issue(make_cmd(MODE_SEEK, 32'd1000, 0, 0, 0, 0), 0, none);

        // Random paths: short tables of mostly rising times, then mostly motion commands.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n > 200 && n < 220)
                set_wrap($urandom_range(0, 1));
            if (n > 500 && n < 520)
            begin
                drain();
                set_wrap(1'b1);
            end
            k = $urandom_range(1, 8);
            t = $urandom;
            for (int w = 0; w < k; w++)
            begin
                c = make_cmd(MODE_LOAD, t, w == 0 && $urandom_range(0, 7) != 0,
                             rand_coord(), rand_coord(), rand_coord());
                issue(c, 0, none);
                n++;
                if ($urandom_range(0, 9) == 0)
                    t = $urandom;
                else
                    t = t + $urandom_range(0, 5000);
            end
            for (int m = $urandom_range(2, 14); m > 0; m--)
            begin
                c = make_cmd(MODE_ADVANCE, $urandom_range(0, 3000), $urandom_range(0, 1),
                             $urandom, $urandom, $urandom);
                case ($urandom_range(0, 9))
                    0: c.tval = $urandom;
                    1: c.mode = MODE_REWIND;
                    2, 3:
                    begin
                        c.mode = MODE_SEEK;
                        c.tval = t - $urandom_range(0, 30000);
                    end
                    4: c.mode = MODE_SEEK;
                    5: c.mode = MODE_LOAD;
                    default: ;
                endcase
                issue(c, 0, none);
                n++;
            end
            if (n > 350 && n < 370)
                drain();
        end

        drain();
        $display("Checked %0d position reports, %0d path ends, %0d full-table drops.",
                 report_count, wrap_count, full_count);
        if (error_count == 0 && pending_positions.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/kfpi_pkg.sv
rtl/kfpi_div.sv
rtl/keyframe_path_interpolator_unit.sv
bench/tb_keyframe_path_interpolator_unit.sv
